### hdl/sqvg_pkg.sv
// ----------------------------------------------------------------------------
// sqvg_pkg: shared types, constants and table functions
// Holds the grid cell word passed from the front end to the vertex back end,
// the angle and saturation constants, and the elaboration-time sine table
// builder.
// ----------------------------------------------------------------------------
`default_nettype none

package sqvg_pkg;

	// Angles in whole degrees.
	localparam int unsigned FULL_TURN = 360;
	localparam int unsigned HALF_TURN = 180;
	localparam int unsigned QUARTER_TURN = 90;
	localparam int unsigned THREE_QUARTER_TURN = 270;
	localparam int unsigned ANG_W = 9;
	localparam int unsigned ANG_SUM_W = 10;
	localparam int unsigned QIDX_W = 7;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAT_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LON_STEP = 2'd2;
	localparam int unsigned RADIUS_W = 15;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd100;
	localparam logic [ANG_W-1:0] STEP_RESET = 9'd20;

	// Output format.
	localparam int unsigned POS_W = 24;
	localparam logic [POS_W-1:0] POS_MAX = 24'h7FFFFF;
	localparam logic [POS_W-1:0] NEG_MAG = 24'h800000;

	// Corner codes within a quad.
	localparam logic [1:0] CORNER_FIRST = 2'd0;
	localparam logic [1:0] CORNER_LAST = 2'd3;

	// Cell queue geometry.
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QCNT_W = 2;

	// Sine table builder working precision.
	localparam int unsigned WORK_FRAC = 30;
	localparam longint unsigned PI_W = 64'd3373259426;

	// One grid cell: base angles, far-corner angles and the final-cell flag.
	typedef struct packed {
		logic [ANG_W-1:0] th0;
		logic [ANG_SUM_W-1:0] th1;
		logic [ANG_W-1:0] ph0;
		logic [ANG_SUM_W-1:0] ph1;
		logic last;
	} cell_t;

	// Fixed-point multiply at the working precision.
	function automatic longint unsigned mul_w(input longint unsigned a,
		input longint unsigned b);
		return (a * b) >> WORK_FRAC;
	endfunction

	// Next Taylor term numerator: t * x * x.
	function automatic longint unsigned term_w(input longint unsigned t,
		input longint unsigned x);
		return mul_w(mul_w(t, x), x);
	endfunction

	// First-quadrant sine of k degrees, rounded to frac fraction bits.
	function automatic int unsigned quarter_sin(input int unsigned k,
		input int unsigned frac);
		longint unsigned x;
		longint unsigned t;
		longint s;
		longint unsigned mag;
		x = (longint'(k) * PI_W + 64'd90) / 180;
		t = x;
		s = longint'(x);
		t = term_w(t, x) / 6;   s = s - longint'(t);
		t = term_w(t, x) / 20;  s = s + longint'(t);
		t = term_w(t, x) / 42;  s = s - longint'(t);
		t = term_w(t, x) / 72;  s = s + longint'(t);
		t = term_w(t, x) / 110; s = s - longint'(t);
		t = term_w(t, x) / 156; s = s + longint'(t);
		t = term_w(t, x) / 210; s = s - longint'(t);
		t = term_w(t, x) / 272; s = s + longint'(t);
		t = term_w(t, x) / 342; s = s - longint'(t);
		t = term_w(t, x) / 420; s = s + longint'(t);
		t = term_w(t, x) / 506; s = s - longint'(t);
		t = term_w(t, x) / 600; s = s + longint'(t);
		if (s < 0) begin
			s = 0;
		end
		mag = ($unsigned(s) + (64'd1 << (WORK_FRAC - 1 - frac))) >> (WORK_FRAC - frac);
		return 32'(mag);
	endfunction

endpackage

`default_nettype wire

### hdl/sphere_quad_vertex_generator.sv
// ----------------------------------------------------------------------------
// sphere_quad_vertex_generator: UV sphere quad vertex generator
// Walks a latitude/longitude grid and emits the four corner vertices of one
// quad per request word, in signed fixed point.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid, in_stall    restart
// out      output     out_valid, out_stall  pos_x, pos_y, pos_z, corner,
//                                           last_corner, last_cell
// cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// Each request word yields four vertex words, one per cycle while out_stall is
// low; the corner sequencer feeds the single vertex pipeline, and a request
// passes through the cell queue and the sequencer's cell register first.
// Reset clears the grid position to zero and loads the register defaults.
// out_stall freezes the vertex pipeline; requests are still taken until the
// two-entry cell queue is full, and in_stall then rises.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_quad_vertex_generator #(
	parameter int unsigned TRIG_FRAC_BITS = 15,
	parameter int unsigned OUT_FRAC_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [sqvg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sqvg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic restart,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [sqvg_pkg::POS_W-1:0] pos_x,
	output logic signed [sqvg_pkg::POS_W-1:0] pos_y,
	output logic signed [sqvg_pkg::POS_W-1:0] pos_z,
	output logic [1:0] corner,
	output logic last_corner,
	output logic last_cell
);

	logic [sqvg_pkg::RADIUS_W-1:0] radius_q;
	logic [sqvg_pkg::ANG_W-1:0] lat_step_q;
	logic [sqvg_pkg::ANG_W-1:0] lon_step_q;
	logic push;
	logic q_full;
	logic q_valid;
	logic q_pop;
	sqvg_pkg::cell_t cell_word;
	sqvg_pkg::cell_t q_head;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= sqvg_pkg::RADIUS_RESET;
			lat_step_q <= sqvg_pkg::STEP_RESET;
			lon_step_q <= sqvg_pkg::STEP_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sqvg_pkg::REG_RADIUS: radius_q <= cfg_data;
				sqvg_pkg::REG_LAT_STEP: lat_step_q <= cfg_data[sqvg_pkg::ANG_W-1:0];
				sqvg_pkg::REG_LON_STEP: lon_step_q <= cfg_data[sqvg_pkg::ANG_W-1:0];
				default: radius_q <= radius_q;
			endcase
		end
	end

	// Grid walker.
	sqvg_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.lat_step(lat_step_q),
		.lon_step(lon_step_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.q_full(q_full),
		.push(push),
		.cell_word(cell_word)
	);

	// Cell queue.
	sqvg_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.cell_in(cell_word),
		.full(q_full),
		.q_valid(q_valid),
		.head(q_head),
		.pop(q_pop)
	);

	// Vertex back end.
	sqvg_back #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.radius(radius_q),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.corner(corner),
		.last_corner(last_corner),
		.last_cell(last_cell)
	);

endmodule

`default_nettype wire

### hdl/sqvg_front.sv
// ----------------------------------------------------------------------------
// sqvg_front: grid walker
// Accepts request words, applies restart, works out the four corner angles
// and the final-cell flag, pushes the cell into the queue and advances the
// grid position.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvg_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [sqvg_pkg::ANG_W-1:0] lat_step,
	input  wire logic [sqvg_pkg::ANG_W-1:0] lon_step,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic restart,
	input  wire logic q_full,
	output logic push,
	output sqvg_pkg::cell_t cell_word
);

	logic [sqvg_pkg::ANG_W-1:0] theta_q;
	logic [sqvg_pkg::ANG_W-1:0] phi_q;
	logic [sqvg_pkg::ANG_W-1:0] du;
	logic [sqvg_pkg::ANG_W-1:0] dv;
	logic [sqvg_pkg::ANG_W-1:0] u;
	logic [sqvg_pkg::ANG_W-1:0] v;
	logic [sqvg_pkg::ANG_SUM_W-1:0] u_far;
	logic [sqvg_pkg::ANG_SUM_W-1:0] v_far;
	logic u_wrap;
	logic v_wrap;

	// Clamp a step into 1..360 degrees.
	function automatic logic [sqvg_pkg::ANG_W-1:0] eff_step(
		input logic [sqvg_pkg::ANG_W-1:0] s);
		if (s == '0) begin
			return sqvg_pkg::ANG_W'(1);
		end
		if (s > sqvg_pkg::ANG_W'(sqvg_pkg::FULL_TURN)) begin
			return sqvg_pkg::ANG_W'(sqvg_pkg::FULL_TURN);
		end
		return s;
	endfunction

	// The front stalls only when the cell queue is full.
	assign in_stall = q_full;
	assign push = in_valid && !q_full;

	// Classify the cell from the current grid position.
	always_comb begin
		du = eff_step(lat_step);
		dv = eff_step(lon_step);
		u = restart ? '0 : theta_q;
		v = restart ? '0 : phi_q;
		u_far = {1'b0, u} + {1'b0, du};
		v_far = {1'b0, v} + {1'b0, dv};
		u_wrap = u_far >= sqvg_pkg::ANG_SUM_W'(sqvg_pkg::FULL_TURN);
		v_wrap = v_far >= sqvg_pkg::ANG_SUM_W'(sqvg_pkg::FULL_TURN);
		cell_word.th0 = u;
		cell_word.th1 = u_far;
		cell_word.ph0 = v;
		cell_word.ph1 = v_far;
		cell_word.last = u_wrap && v_wrap;
	end

	// Step phi, and theta when phi wraps; both restart from zero on a wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_q <= '0;
			phi_q <= '0;
		end else if (push) begin
			if (v_wrap) begin
				phi_q <= '0;
				theta_q <= u_wrap ? '0 : u_far[sqvg_pkg::ANG_W-1:0];
			end else begin
				phi_q <= v_far[sqvg_pkg::ANG_W-1:0];
				theta_q <= u;
			end
		end
	end

`ifndef SYNTHESIS
	a_grid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		theta_q < sqvg_pkg::ANG_W'(sqvg_pkg::FULL_TURN)
		&& phi_q < sqvg_pkg::ANG_W'(sqvg_pkg::FULL_TURN))
		else $error("grid position left the 0..359 range");
`endif

endmodule

`default_nettype wire

### hdl/sqvg_queue.sv
// ----------------------------------------------------------------------------
// sqvg_queue: cell queue
// Two-entry first-in first-out store of cell words between the grid walker
// and the vertex back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvg_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire sqvg_pkg::cell_t cell_in,
	output logic full,
	output logic q_valid,
	output sqvg_pkg::cell_t head,
	input  wire logic pop
);

	sqvg_pkg::cell_t mem_q [sqvg_pkg::QDEPTH];
	logic [sqvg_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sqvg_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sqvg_pkg::QCNT_W-1:0] count_q;

	assign full = count_q == sqvg_pkg::QCNT_W'(sqvg_pkg::QDEPTH);
	assign q_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cell_in;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("cell pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("cell popped from an empty queue");
`endif

endmodule

`default_nettype wire

### hdl/sqvg_back.sv
// ----------------------------------------------------------------------------
// sqvg_back: vertex back end
// Steps through the four corners of each queued cell, one per cycle while the
// output is not stalled, and runs each corner through angle wrap, sine lookup,
// two multiplies and rounding with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvg_back #(
	parameter int unsigned TRIG_FRAC_BITS = 15,
	parameter int unsigned OUT_FRAC_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [sqvg_pkg::RADIUS_W-1:0] radius,
	input  wire logic q_valid,
	input  wire sqvg_pkg::cell_t q_head,
	output logic q_pop,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [sqvg_pkg::POS_W-1:0] pos_x,
	output logic signed [sqvg_pkg::POS_W-1:0] pos_y,
	output logic signed [sqvg_pkg::POS_W-1:0] pos_z,
	output logic [1:0] corner,
	output logic last_corner,
	output logic last_cell
);

	localparam int unsigned QW = TRIG_FRAC_BITS + 1;
	localparam int unsigned TW = TRIG_FRAC_BITS + 2;
	localparam int unsigned P1 = 2 * TW;
	localparam int unsigned P2 = P1 + sqvg_pkg::RADIUS_W + 1;
	localparam int SH = 2 * int'(TRIG_FRAC_BITS) - int'(OUT_FRAC_BITS);
	localparam int HALF_SH = (SH > 0) ? SH - 1 : 0;
	localparam int unsigned QENTRIES = sqvg_pkg::QUARTER_TURN + 1;

	// First-quadrant sine table, built at elaboration.
	logic [QW-1:0] qtab [QENTRIES];

	for (genvar k = 0; k < QENTRIES; k++) begin : g_qtab
		assign qtab[k] = QW'(sqvg_pkg::quarter_sin(k, TRIG_FRAC_BITS));
	end

	// Sequencer state.
	sqvg_pkg::cell_t cell_q;
	logic busy_q;
	logic [1:0] corner_q;
	logic en;
	logic issue;
	logic [sqvg_pkg::ANG_SUM_W-1:0] th_sel;
	logic [sqvg_pkg::ANG_SUM_W-1:0] ph_sel;
	logic [sqvg_pkg::ANG_W-1:0] th_w;
	logic [sqvg_pkg::ANG_W-1:0] ph_w;

	// Pipeline stages.
	logic v_s1, v_s2, v_s3, v_s4;
	logic [sqvg_pkg::ANG_W-1:0] st_ang_s1, ct_ang_s1, sp_ang_s1, cp_ang_s1;
	logic [1:0] corner_s1, corner_s2, corner_s3, corner_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [TW-1:0] st_s2, ct_s2, sp_s2, cp_s2;
	logic signed [P1-1:0] xp_s3, yp_s3, zp_s3;
	logic signed [P2-1:0] x_s4, y_s4, z_s4;
	logic signed [sqvg_pkg::RADIUS_W:0] r_signed;

	// Wrap an angle below two turns into 0..359.
	function automatic logic [sqvg_pkg::ANG_W-1:0] wrap_angle(
		input logic [sqvg_pkg::ANG_SUM_W-1:0] a);
		logic [sqvg_pkg::ANG_SUM_W-1:0] w;
		w = (a >= sqvg_pkg::ANG_SUM_W'(sqvg_pkg::FULL_TURN))
			? a - sqvg_pkg::ANG_SUM_W'(sqvg_pkg::FULL_TURN) : a;
		return w[sqvg_pkg::ANG_W-1:0];
	endfunction

	// Quarter-turn shift of a wrapped angle, for cosine.
	function automatic logic [sqvg_pkg::ANG_W-1:0] cos_angle(
		input logic [sqvg_pkg::ANG_W-1:0] a);
		return wrap_angle({1'b0, a} + sqvg_pkg::ANG_SUM_W'(sqvg_pkg::QUARTER_TURN));
	endfunction

	// Full-circle sine by quadrant folding of the table.
	function automatic logic signed [TW-1:0] sin_of(input logic [sqvg_pkg::ANG_W-1:0] a);
		logic [sqvg_pkg::ANG_W-1:0] idx;
		logic neg;
		logic signed [TW-1:0] m;
		if (a <= sqvg_pkg::ANG_W'(sqvg_pkg::QUARTER_TURN)) begin
			idx = a;
			neg = 1'b0;
		end else if (a <= sqvg_pkg::ANG_W'(sqvg_pkg::HALF_TURN)) begin
			idx = sqvg_pkg::ANG_W'(sqvg_pkg::HALF_TURN) - a;
			neg = 1'b0;
		end else if (a <= sqvg_pkg::ANG_W'(sqvg_pkg::THREE_QUARTER_TURN)) begin
			idx = a - sqvg_pkg::ANG_W'(sqvg_pkg::HALF_TURN);
			neg = 1'b1;
		end else begin
			idx = sqvg_pkg::ANG_W'(sqvg_pkg::FULL_TURN) - a;
			neg = 1'b1;
		end
		m = $signed({1'b0, qtab[idx[sqvg_pkg::QIDX_W-1:0]]});
		return neg ? -m : m;
	endfunction

	// Round half away from zero to the output fraction and saturate.
	function automatic logic [sqvg_pkg::POS_W-1:0] round_sat(input logic signed [P2-1:0] v);
		logic neg;
		logic [P2-1:0] mag;
		neg = v[P2-1];
		mag = neg ? $unsigned(-v) : $unsigned(v);
		if (SH > 0) begin
			mag = (mag + (P2'(1) << HALF_SH)) >> SH;
		end
		if (neg) begin
			if (mag > P2'(sqvg_pkg::NEG_MAG)) begin
				mag = P2'(sqvg_pkg::NEG_MAG);
			end
			return sqvg_pkg::POS_W'(0) - mag[sqvg_pkg::POS_W-1:0];
		end
		if (mag > P2'(sqvg_pkg::POS_MAX)) begin
			mag = P2'(sqvg_pkg::POS_MAX);
		end
		return mag[sqvg_pkg::POS_W-1:0];
	endfunction

	// The whole pipeline holds while a finished word waits at the output.
	assign en = !(out_valid && out_stall);
	assign issue = en && busy_q;
	assign q_pop = en && q_valid && (!busy_q || corner_q == sqvg_pkg::CORNER_LAST);
	assign r_signed = $signed({1'b0, radius});

	// Corner angles: theta takes the far edge on corners one and two, phi on
	// corners two and three.
	always_comb begin
		th_sel = (corner_q[0] ^ corner_q[1]) ? cell_q.th1 : {1'b0, cell_q.th0};
		ph_sel = corner_q[1] ? cell_q.ph1 : {1'b0, cell_q.ph0};
		th_w = wrap_angle(th_sel);
		ph_w = wrap_angle(ph_sel);
	end

	// Corner sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			corner_q <= sqvg_pkg::CORNER_FIRST;
		end else if (en) begin
			if (q_pop) begin
				busy_q <= 1'b1;
				corner_q <= sqvg_pkg::CORNER_FIRST;
			end else if (busy_q) begin
				if (corner_q == sqvg_pkg::CORNER_LAST) begin
					busy_q <= 1'b0;
				end
				corner_q <= corner_q + 1'b1;
			end
		end
	end

	// Current cell word.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cell_q <= q_head;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	// Stage payload: wrapped angles, sines, products, scaled products, result.
	always_ff @(posedge clk) begin
		if (en) begin
			st_ang_s1 <= th_w;
			ct_ang_s1 <= cos_angle(th_w);
			sp_ang_s1 <= ph_w;
			cp_ang_s1 <= cos_angle(ph_w);
			corner_s1 <= corner_q;
			last_s1 <= cell_q.last;

			st_s2 <= sin_of(st_ang_s1);
			ct_s2 <= sin_of(ct_ang_s1);
			sp_s2 <= sin_of(sp_ang_s1);
			cp_s2 <= sin_of(cp_ang_s1);
			corner_s2 <= corner_s1;
			last_s2 <= last_s1;

			xp_s3 <= st_s2 * cp_s2;
			zp_s3 <= sp_s2 * st_s2;
			yp_s3 <= {{(P1 - TW){ct_s2[TW-1]}}, ct_s2} <<< TRIG_FRAC_BITS;
			corner_s3 <= corner_s2;
			last_s3 <= last_s2;

			x_s4 <= r_signed * xp_s3;
			y_s4 <= r_signed * yp_s3;
			z_s4 <= r_signed * zp_s3;
			corner_s4 <= corner_s3;
			last_s4 <= last_s3;

			pos_x <= $signed(round_sat(x_s4));
			pos_y <= $signed(round_sat(y_s4));
			pos_z <= $signed(round_sat(z_s4));
			corner <= corner_s4;
			last_corner <= corner_s4 == sqvg_pkg::CORNER_LAST;
			last_cell <= last_s4;
		end
	end

`ifndef SYNTHESIS
	a_idle_after_quad: assert property (@(posedge clk) disable iff (!arst_n)
		issue && corner_q == sqvg_pkg::CORNER_LAST && !q_pop |=> !busy_q)
		else $error("sequencer stayed busy after the last corner");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !issue && !q_pop)
		else $error("sequencer moved while the output was stalled");
`endif

endmodule

`default_nettype wire
